@@ rtl/core/hsrt_pkg.sv @@
`timescale 1ns / 1ps

package hsrt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int SEQ_W       = 64;
	localparam int TRY_W       = 8;

	localparam logic [TRY_W-1:0] MAX_TRIES_RST = TRY_W'(3);

	typedef enum logic [1:0] {
		OUT_RAISED  = 2'd0,
		OUT_ADDED   = 2'd1,
		OUT_REMOVED = 2'd2,
		OUT_FULL    = 2'd3
	} outcome_t;

	typedef struct packed {
		logic load;
		logic step;
		logic rd_last;
		logic bump;
		logic append;
		logic move;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic hit;
		logic under;
		logic cmp_last;
	} dp_sts_t;

endpackage

@@ rtl/core/hsrt_datapath.sv @@
`timescale 1ns / 1ps

module hsrt_datapath import hsrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SEQ_W-1:0] seq,
	input  logic             cfg_wr,
	input  logic [TRY_W-1:0] cfg_data,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts
);

	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

	logic [SEQ_W-1:0] seq_mem [TABLE_DEPTH];
	logic [TRY_W-1:0] cnt_mem [TABLE_DEPTH];

	logic [SEQ_W-1:0] seq_q;
	logic [SEQ_W-1:0] rd_seq_q;
	logic [TRY_W-1:0] rd_cnt_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic [IDX_W-1:0] cmp_q;
	logic [TRY_W-1:0] max_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] last_idx;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [SEQ_W-1:0] wr_seq;
	logic [TRY_W-1:0] wr_cnt;
	logic [TRY_W-1:0] bumped;
	logic [CNT_W-1:0] last_cnt;
	logic [CNT_W-1:0] cmp_next;

	assign last_cnt = count_q - CNT_ONE;
	assign last_idx = last_cnt[IDX_W-1:0];
	assign cmp_next = CNT_W'(cmp_q) + CNT_ONE;
	assign bumped   = rd_cnt_q + TRY_W'(1);

	assign rd_en   = cmd.step | cmd.rd_last;
	assign rd_addr = cmd.step ? scan_q[IDX_W-1:0] : last_idx;

	always_comb begin
		wr_en   = cmd.bump | cmd.append | cmd.move;
		wr_addr = cmp_q;
		wr_seq  = rd_seq_q;
		wr_cnt  = rd_cnt_q;
		if (cmd.bump) begin
			wr_cnt = bumped;
		end else if (cmd.append) begin
			wr_addr = count_q[IDX_W-1:0];
			wr_seq  = seq_q;
			wr_cnt  = TRY_W'(1);
		end
	end

	assign sts.empty    = (count_q == '0);
	assign sts.full     = (count_q == CNT_FULL);
	assign sts.hit      = (rd_seq_q == seq_q);
	assign sts.under    = (bumped < max_q);
	assign sts.cmp_last = (cmp_next == count_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q <= seq;
		end
		if (rd_en) begin
			rd_seq_q <= seq_mem[rd_addr];
			rd_cnt_q <= cnt_mem[rd_addr];
		end
		if (wr_en) begin
			seq_mem[wr_addr] <= wr_seq;
			cnt_mem[wr_addr] <= wr_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q  <= '0;
			cmp_q   <= '0;
			max_q   <= MAX_TRIES_RST;
		end else begin
			if (cfg_wr) begin
				max_q <= cfg_data;
			end
			if (cmd.load) begin
				scan_q <= '0;
			end else if (cmd.step) begin
				cmp_q  <= scan_q[IDX_W-1:0];
				scan_q <= scan_q + CNT_ONE;
			end
			if (cmd.append) begin
				count_q <= count_q + CNT_ONE;
			end else if (cmd.move) begin
				count_q <= last_cnt;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count above table depth");

	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> !sts.full)
		else $error("append into full table");

	a_move_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> !sts.empty && (CNT_W'(cmp_q) < count_q))
		else $error("remove outside valid entries");

endmodule

@@ rtl/core/hsrt_ctrl.sv @@
`timescale 1ns / 1ps

module hsrt_ctrl import hsrt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy,
	output logic    done,
	output logic    hold,
	output logic [1:0] outcome
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_CMP,
		S_MOVE
	} state_t;

	state_t   state_q;
	logic     busy_q;
	logic     done_q;
	logic     hold_q;
	outcome_t outcome_q;
	logic     accept;

	assign accept  = start && !busy_q;
	assign busy    = busy_q;
	assign done    = done_q;
	assign hold    = hold_q;
	assign outcome = outcome_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = accept;
			end
			S_ISSUE: begin
				if (sts.empty) begin
					cmd.append = 1'b1;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_CMP: begin
				if (sts.hit) begin
					if (sts.under) begin
						cmd.bump = 1'b1;
					end else begin
						cmd.rd_last = 1'b1;
					end
				end else if (sts.cmp_last) begin
					cmd.append = !sts.full;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_MOVE: begin
				cmd.move = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			hold_q    <= 1'b0;
			outcome_q <= OUT_RAISED;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						busy_q  <= 1'b1;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (sts.empty) begin
						done_q    <= 1'b1;
						hold_q    <= 1'b1;
						outcome_q <= OUT_ADDED;
						busy_q    <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (sts.hit) begin
						if (sts.under) begin
							done_q    <= 1'b1;
							hold_q    <= 1'b1;
							outcome_q <= OUT_RAISED;
							busy_q    <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							state_q <= S_MOVE;
						end
					end else if (sts.cmp_last) begin
						done_q    <= 1'b1;
						hold_q    <= !sts.full;
						outcome_q <= sts.full ? OUT_FULL : OUT_ADDED;
						busy_q    <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				S_MOVE: begin
					done_q    <= 1'b1;
					hold_q    <= 1'b0;
					outcome_q <= OUT_REMOVED;
					busy_q    <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("result without item in flight");

	a_hold_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (hold_q == (outcome_q == OUT_RAISED || outcome_q == OUT_ADDED)))
		else $error("hold disagrees with outcome");

	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy flag out of step with state");

endmodule

@@ rtl/core/held_sequence_retry_table.sv @@
`timescale 1ns / 1ps
// channel  | signals                      | handshake
// ---------+------------------------------+------------------------------
// item in  | start, busy, seq[63:0]       | taken when start && !busy
// result   | done, hold, outcome[1:0]     | one-cycle strobe on done
// config   | cfg_valid, cfg_ready, cfg_data | written when valid && ready
//
// An item that misses or raises a count scans the entries, one memory read
// per cycle, before its result; a removal passes through S_MOVE as well,
// and an item on an empty table is appended without a scan.
// busy drops in the result cycle, so the next item may start then.
// arst_n clears the entry count and loads max_tries with 3; table contents
// are not cleared. Results cannot be stalled; cfg_ready is always high.

module held_sequence_retry_table import hsrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [SEQ_W-1:0] seq,
	output logic             done,
	output logic             hold,
	output logic [1:0]       outcome,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [TRY_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	hsrt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.hold    (hold),
		.outcome (outcome)
	);

	hsrt_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.seq      (seq),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

@@ test/retry_checker.sv @@
`timescale 1ns / 1ps

module retry_checker import hsrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [SEQ_W-1:0] seq,
	input  logic             done,
	input  logic             hold,
	input  logic [1:0]       outcome,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [TRY_W-1:0] cfg_data,
	output int               fail_count,
	output int               items_seen,
	output int               results_seen,
	output int               pending
);

	localparam logic [TRY_W-1:0] LIMIT_AT_RESET = 8'd3;

	typedef struct packed {
		logic     hold;
		outcome_t outcome;
	} verdict_t;

	logic [SEQ_W-1:0] held_seq   [TABLE_DEPTH];
	logic [TRY_W-1:0] held_tries [TABLE_DEPTH];
	int               held_used;
	logic [TRY_W-1:0] try_limit;
	verdict_t         expected_verdicts [$];

	// scan from entry 0; removal moves the last entry into the freed slot
	function automatic verdict_t track_retry(input logic [SEQ_W-1:0] value);
		logic [TRY_W-1:0] bumped;
		for (int i = 0; i < held_used; i++) begin
			if (held_seq[i] == value) begin
				bumped = held_tries[i] + 1'b1;
				if (bumped < try_limit) begin
					held_tries[i] = bumped;
					return '{1'b1, OUT_RAISED};
				end
				held_used--;
				held_seq[i]   = held_seq[held_used];
				held_tries[i] = held_tries[held_used];
				return '{1'b0, OUT_REMOVED};
			end
		end
		if (held_used >= TABLE_DEPTH)
			return '{1'b0, OUT_FULL};
		held_seq[held_used]   = value;
		held_tries[held_used] = 8'd1;
		held_used++;
		return '{1'b1, OUT_ADDED};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		int       bad;
		if (!arst_n) begin
			held_used = 0;
			try_limit = LIMIT_AT_RESET;
			expected_verdicts.delete();
			fail_count   <= 0;
			items_seen   <= 0;
			results_seen <= 0;
		end else begin
			bad = 0;
			if (done) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: unexpected result: expected none, got hold %0b outcome %0d",
						$time, hold, outcome);
					bad++;
				end else begin
					want = expected_verdicts.pop_front();
					if (hold !== want.hold) begin
						$display("%0t: hold mismatch: expected %0b, got %0b",
							$time, want.hold, hold);
						bad++;
					end
					if (outcome !== want.outcome) begin
						$display("%0t: outcome mismatch: expected %0d, got %0d",
							$time, want.outcome, outcome);
						bad++;
					end
				end
				results_seen <= results_seen + 1;
			end
			if (start && !busy) begin
				expected_verdicts.push_back(track_retry(seq));
				items_seen <= items_seen + 1;
			end
			if (cfg_valid && cfg_ready)
				try_limit = cfg_data;
			fail_count <= fail_count + bad;
		end
	end

	assign pending = items_seen - results_seen;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import hsrt_pkg::*;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 147;
	localparam int POOL_SIZE       = 20;
	localparam int FILL_COUNT      = 15;
	localparam int MAX_GAP         = 24;
	localparam int SETTLE_CYCLES   = 25;
	localparam int WATCHDOG_CYCLES = 500;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic [SEQ_W-1:0] seq       = '0;
	logic             cfg_valid = 1'b0;
	logic [TRY_W-1:0] cfg_data  = '0;
	logic             busy;
	logic             done;
	logic             hold;
	logic [1:0]       outcome;
	logic             cfg_ready;

	int fail_count;
	int items_seen;
	int results_seen;
	int pending;
	int idle_pct   = 0;
	int cfg_writes = 0;
	int quiet      = 0;

	logic [SEQ_W-1:0] seq_pool [POOL_SIZE];

	held_sequence_retry_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.seq       (seq),
		.done      (done),
		.hold      (hold),
		.outcome   (outcome),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	retry_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.seq          (seq),
		.done         (done),
		.hold         (hold),
		.outcome      (outcome),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.items_seen   (items_seen),
		.results_seen (results_seen),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet <= 0;
			end else if (quiet == WATCHDOG_CYCLES) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_CYCLES);
				$display("testbench: FAIL");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	function automatic logic [SEQ_W-1:0] fill_seq(input int k);
		return (64'h8000_0000_0000_0000 >> k) | 64'(k);
	endfunction

	function automatic logic [SEQ_W-1:0] fresh_seq();
		return {$urandom, $urandom};
	endfunction

	// start stays high after acceptance; the next call drives it at the falling edge
	task automatic send_seq(input logic [SEQ_W-1:0] value);
		@(negedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
		end
		start <= 1'b1;
		seq   <= value;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	task automatic write_limit(input logic [TRY_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	initial begin
		logic [TRY_W-1:0] limit;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// limit 3 from reset: add, raise, remove, then fill to capacity
		send_seq(64'h0);
		send_seq(64'h0);
		send_seq(64'h0);
		send_seq(64'hFFFF_FFFF_FFFF_FFFF);
		for (int k = 0; k < FILL_COUNT; k++)
			send_seq(fill_seq(k));
		send_seq(64'h0123_4567_89AB_CDEF);
		// limits of zero and one release on first match
		write_limit(8'd0);
		send_seq(64'hFFFF_FFFF_FFFF_FFFF);
		write_limit(8'd1);
		send_seq(fill_seq(0));
		// count left above a lowered limit
		write_limit(8'd12);
		send_seq(fill_seq(1));
		send_seq(fill_seq(1));
		write_limit(8'd2);
		send_seq(fill_seq(1));

		for (int k = 0; k < POOL_SIZE; k++)
			seq_pool[k] = (k < FILL_COUNT) ? fill_seq(k) : fresh_seq();
		seq_pool[FILL_COUNT]     = 64'h0;
		seq_pool[FILL_COUNT + 1] = 64'hFFFF_FFFF_FFFF_FFFF;

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: limit = 8'd3;
				1: limit = 8'd1;
				2: limit = 8'd255;
				3: limit = 8'd2;
				4: limit = 8'd0;
				5: limit = 8'($urandom_range(2, 9));
				6: limit = 8'd255;
				default: limit = 8'd4;
			endcase
			case (p % 4)
				0: idle_pct = 0;
				1: idle_pct = 48;
				2: idle_pct = 33;
				default: idle_pct = 48;
			endcase
			if (p == PHASES - 1)
				idle_pct = 0;
			write_limit(limit);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 99) == 0)
					drain();
				if ($urandom_range(0, 19) == 0)
					seq_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_seq();
				if ($urandom_range(0, 3) != 0)
					send_seq(seq_pool[$urandom_range(0, POOL_SIZE - 1)]);
				else
					send_seq(fresh_seq());
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d items and %0d results over %0d limit writes,", items_seen,
			results_seen, cfg_writes);
		$display("limits 0, 1, 2 and 255 included, table run full and lowered limits hit");
		if (fail_count == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
